// ===== design/rsi_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the ray/segment intersection unit.
// No dependencies; used by the top level and the port checker.
package rsi_pkg;

    // Default coordinate width, signed Q12.4 at 16 bits.
    localparam int COORD_BITS = 16;

    // Index of each coordinate inside the packed coordinate word.
    localparam int C_X0 = 0;
    localparam int C_Y0 = 1;
    localparam int C_X1 = 2;
    localparam int C_Y1 = 3;
    localparam int C_U0 = 4;
    localparam int C_V0 = 5;
    localparam int C_U1 = 6;
    localparam int C_V1 = 7;
    localparam int N_COORDS = 8;

endpackage

// ===== design/rsi_div_step.sv =====
`timescale 1ns / 1ps
// One restoring-division stage, shared by the x and y numerators.
// Depends on nothing; instantiated COORD_BITS+1 times by the top level.
module rsi_div_step #(
    parameter int QW    = 16,
    parameter int NW    = 51,
    parameter int DW    = 35,
    parameter int SHIFT = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_rem_x,
    input  logic [NW-1:0] i_rem_y,
    input  logic [QW-1:0] i_q_x,
    input  logic [QW-1:0] i_q_y,
    input  logic [DW-1:0] i_d,
    input  logic          i_big,
    output logic [NW-1:0] o_rem_x,
    output logic [NW-1:0] o_rem_y,
    output logic [QW-1:0] o_q_x,
    output logic [QW-1:0] o_q_y,
    output logic [DW-1:0] o_d,
    output logic          o_big
);

    localparam bit IS_TOP = (SHIFT == QW);

    logic [NW-1:0] dsh;
    logic          ge_x;
    logic          ge_y;
    logic [NW-1:0] n_rem_x;
    logic [NW-1:0] n_rem_y;
    logic [QW-1:0] n_q_x;
    logic [QW-1:0] n_q_y;
    logic          n_big;
    logic [NW-1:0] r_rem_x;
    logic [NW-1:0] r_rem_y;
    logic [QW-1:0] r_q_x;
    logic [QW-1:0] r_q_y;
    logic [DW-1:0] r_d;
    logic          r_big;

    assign dsh  = NW'(i_d) << SHIFT;
    assign ge_x = (i_rem_x >= dsh);
    assign ge_y = (i_rem_y >= dsh);

    always_comb begin
        n_rem_x = i_rem_x;
        n_rem_y = i_rem_y;
        n_q_x   = i_q_x;
        n_q_y   = i_q_y;
        n_big   = i_big;
        if (IS_TOP) begin
            // quotient would need more than QW bits: outside any segment box
            n_big = i_big | ge_x | ge_y;
        end else begin
            if (ge_x) begin
                n_rem_x = i_rem_x - dsh;
                n_q_x   = i_q_x | (QW'(1) << SHIFT);
            end
            if (ge_y) begin
                n_rem_y = i_rem_y - dsh;
                n_q_y   = i_q_y | (QW'(1) << SHIFT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_q_x   <= n_q_x;
            r_q_y   <= n_q_y;
            r_d     <= i_d;
            r_big   <= n_big;
        end
    end

    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_q_x   = r_q_x;
    assign o_q_y   = r_q_y;
    assign o_d     = r_d;
    assign o_big   = r_big;

endmodule

// ===== design/ray_segment_intersect_unit.sv =====
`timescale 1ns / 1ps
// Ray versus wall-segment intersection, fully pipelined.
// Depends on rsi_pkg and rsi_div_step.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  input   | i_valid / o_stall      | i_ray_start_x/y, i_ray_dir_x/y,
//          |                        | i_seg_start_x/y, i_seg_end_x/y
//  output  | o_valid / i_stall      | o_hit, o_point_x, o_point_y
//
// Throughput is one transaction per cycle unless the output stalls; there are
// five arithmetic stages, COORD_BITS+1 division stages and one output stage.
// Restoring divider: first stage flags overflow, then one quotient bit per stage.
// Reset clears only the valid bits; data registers carry no reset.
// A stalled result freezes the whole pipeline; the input is stalled exactly
// while a result is held, so nothing is dropped or repeated.
module ray_segment_intersect_unit #(
    parameter int COORD_BITS = rsi_pkg::COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_ray_start_x,
    input  logic signed [COORD_BITS-1:0] i_ray_start_y,
    input  logic signed [COORD_BITS-1:0] i_ray_dir_x,
    input  logic signed [COORD_BITS-1:0] i_ray_dir_y,
    input  logic signed [COORD_BITS-1:0] i_seg_start_x,
    input  logic signed [COORD_BITS-1:0] i_seg_start_y,
    input  logic signed [COORD_BITS-1:0] i_seg_end_x,
    input  logic signed [COORD_BITS-1:0] i_seg_end_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic signed [COORD_BITS-1:0] o_point_x,
    output logic signed [COORD_BITS-1:0] o_point_y
);

    localparam int N    = COORD_BITS;
    localparam int AW   = N + 1;         // line coefficients a, b
    localparam int PW   = 2 * N;         // coordinate products
    localparam int CW   = 2 * N + 1;     // line constant c
    localparam int DPW  = 2 * AW;        // det partial products
    localparam int DW   = 2 * N + 3;     // determinant
    localparam int NPW  = AW + CW;       // numerator partial products
    localparam int NW   = 3 * N + 3;     // numerators
    localparam int SW   = N + 2;         // signed quotient for range checks
    localparam int NDIV = N + 1;         // division stages
    localparam int NSTG = 5 + NDIV;      // stages before the output register
    localparam int NC   = rsi_pkg::N_COORDS;

    typedef logic signed [N-1:0] t_coord;

    logic en;
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    // coordinates and valid bits travel beside the arithmetic
    logic [NC-1:0][N-1:0] in_coord;
    logic [NC-1:0][N-1:0] r_coord [NSTG];
    logic                 r_vld   [NSTG];

    assign in_coord[rsi_pkg::C_X0] = i_ray_start_x;
    assign in_coord[rsi_pkg::C_Y0] = i_ray_start_y;
    assign in_coord[rsi_pkg::C_X1] = i_ray_dir_x;
    assign in_coord[rsi_pkg::C_Y1] = i_ray_dir_y;
    assign in_coord[rsi_pkg::C_U0] = i_seg_start_x;
    assign in_coord[rsi_pkg::C_V0] = i_seg_start_y;
    assign in_coord[rsi_pkg::C_U1] = i_seg_end_x;
    assign in_coord[rsi_pkg::C_V1] = i_seg_end_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSTG; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < NSTG; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_coord[0] <= in_coord;
            for (int i = 1; i < NSTG; i++) begin
                r_coord[i] <= r_coord[i-1];
            end
        end
    end

    // stage 1: coefficients a, b and the products that form c
    logic signed [AW-1:0] r1_a1, r1_b1, r1_a2, r1_b2;
    logic signed [PW-1:0] r1_yx, r1_xy, r1_vu, r1_uv;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a1 <= AW'(i_ray_dir_y) - AW'(i_ray_start_y);
            r1_b1 <= AW'(i_ray_start_x) - AW'(i_ray_dir_x);
            r1_a2 <= AW'(i_seg_end_y) - AW'(i_seg_start_y);
            r1_b2 <= AW'(i_seg_start_x) - AW'(i_seg_end_x);
            r1_yx <= PW'(i_ray_start_y) * PW'(i_ray_dir_x);
            r1_xy <= PW'(i_ray_start_x) * PW'(i_ray_dir_y);
            r1_vu <= PW'(i_seg_start_y) * PW'(i_seg_end_x);
            r1_uv <= PW'(i_seg_start_x) * PW'(i_seg_end_y);
        end
    end

    // stage 2: c terms and determinant products
    logic signed [AW-1:0]  r2_a1, r2_b1, r2_a2, r2_b2;
    logic signed [CW-1:0]  r2_c1, r2_c2;
    logic signed [DPW-1:0] r2_ab, r2_ba;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_a1 <= r1_a1;
            r2_b1 <= r1_b1;
            r2_a2 <= r1_a2;
            r2_b2 <= r1_b2;
            r2_c1 <= CW'(r1_yx) - CW'(r1_xy);
            r2_c2 <= CW'(r1_vu) - CW'(r1_uv);
            r2_ab <= DPW'(r1_a1) * DPW'(r1_b2);
            r2_ba <= DPW'(r1_a2) * DPW'(r1_b1);
        end
    end

    // stage 3: determinant and numerator products
    logic signed [DW-1:0]  r3_det;
    logic signed [NPW-1:0] r3_bc2, r3_bc1, r3_ac1, r3_ac2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_det <= DW'(r2_ab) - DW'(r2_ba);
            r3_bc2 <= NPW'(r2_b1) * NPW'(r2_c2);
            r3_bc1 <= NPW'(r2_b2) * NPW'(r2_c1);
            r3_ac1 <= NPW'(r2_a2) * NPW'(r2_c1);
            r3_ac2 <= NPW'(r2_a1) * NPW'(r2_c2);
        end
    end

    // stage 4: numerators
    logic signed [DW-1:0] r4_det;
    logic signed [NW-1:0] r4_nx, r4_ny;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_det <= r3_det;
            r4_nx  <= NW'(r3_bc2) - NW'(r3_bc1);
            r4_ny  <= NW'(r3_ac1) - NW'(r3_ac2);
        end
    end

    // stage 5: magnitudes, quotient signs and the zero-determinant flag
    logic [NW-1:0] r5_mx, r5_my;
    logic [DW-1:0] r5_d;
    logic          r5_negx, r5_negy, r5_detz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_mx   <= r4_nx[NW-1] ? NW'(-r4_nx) : NW'(r4_nx);
            r5_my   <= r4_ny[NW-1] ? NW'(-r4_ny) : NW'(r4_ny);
            r5_d    <= r4_det[DW-1] ? DW'(-r4_det) : DW'(r4_det);
            r5_negx <= r4_nx[NW-1] ^ r4_det[DW-1];
            r5_negy <= r4_ny[NW-1] ^ r4_det[DW-1];
            r5_detz <= (r4_det == '0);
        end
    end

    // division stages; the first one only flags an oversized quotient
    logic [NW-1:0] dv_rem_x [NDIV+1];
    logic [NW-1:0] dv_rem_y [NDIV+1];
    logic [N-1:0]  dv_q_x   [NDIV+1];
    logic [N-1:0]  dv_q_y   [NDIV+1];
    logic [DW-1:0] dv_d     [NDIV+1];
    logic          dv_big   [NDIV+1];
    logic [2:0]    r_flag   [NDIV];   // {negx, negy, detz}

    assign dv_rem_x[0] = r5_mx;
    assign dv_rem_y[0] = r5_my;
    assign dv_q_x[0]   = '0;
    assign dv_q_y[0]   = '0;
    assign dv_d[0]     = r5_d;
    assign dv_big[0]   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flag[0] <= {r5_negx, r5_negy, r5_detz};
            for (int i = 1; i < NDIV; i++) begin
                r_flag[i] <= r_flag[i-1];
            end
        end
    end

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        rsi_div_step #(
            .QW    (N),
            .NW    (NW),
            .DW    (DW),
            .SHIFT (N - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_rem_x (dv_rem_x[g]),
            .i_rem_y (dv_rem_y[g]),
            .i_q_x   (dv_q_x[g]),
            .i_q_y   (dv_q_y[g]),
            .i_d     (dv_d[g]),
            .i_big   (dv_big[g]),
            .o_rem_x (dv_rem_x[g+1]),
            .o_rem_y (dv_rem_y[g+1]),
            .o_q_x   (dv_q_x[g+1]),
            .o_q_y   (dv_q_y[g+1]),
            .o_d     (dv_d[g+1]),
            .o_big   (dv_big[g+1])
        );
    end

    // output stage: signs, box test, forward test
    logic [NC-1:0][N-1:0] fc;
    logic [2:0]           ff;
    logic signed [SW-1:0] qx_u, qy_u, px, py;
    logic signed [SW-1:0] x0, y0, x1, y1, u0, v0, u1, v1;
    logic                 in_box, fwd, n_hit;
    logic                 r_ovld, r_hit;
    t_coord               r_px, r_py;

    assign fc = r_coord[NSTG-1];
    assign ff = r_flag[NDIV-1];

    always_comb begin
        qx_u = $signed({2'b00, dv_q_x[NDIV]});
        qy_u = $signed({2'b00, dv_q_y[NDIV]});
        px   = ff[2] ? -qx_u : qx_u;
        py   = ff[1] ? -qy_u : qy_u;
        x0   = SW'(t_coord'(fc[rsi_pkg::C_X0]));
        y0   = SW'(t_coord'(fc[rsi_pkg::C_Y0]));
        x1   = SW'(t_coord'(fc[rsi_pkg::C_X1]));
        y1   = SW'(t_coord'(fc[rsi_pkg::C_Y1]));
        u0   = SW'(t_coord'(fc[rsi_pkg::C_U0]));
        v0   = SW'(t_coord'(fc[rsi_pkg::C_V0]));
        u1   = SW'(t_coord'(fc[rsi_pkg::C_U1]));
        v1   = SW'(t_coord'(fc[rsi_pkg::C_V1]));
        // inclusive box, either endpoint order
        in_box = ((px >= u0 && px <= u1) || (px >= u1 && px <= u0))
              && ((py >= v0 && py <= v1) || (py >= v1 && py <= v0));
        fwd    = ((px > x0) == (x1 > x0)) && ((py > y0) == (y1 > y0));
        n_hit  = !ff[0] && !dv_big[NDIV] && in_box && fwd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= n_hit;
            r_px  <= n_hit ? t_coord'(px[N-1:0]) : '0;
            r_py  <= n_hit ? t_coord'(py[N-1:0]) : '0;
        end
    end

    assign o_valid   = r_ovld;
    assign o_hit     = r_hit;
    assign o_point_x = r_px;
    assign o_point_y = r_py;

endmodule

// ===== design/rsi_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for ray_segment_intersect_unit, attached by bind.
// Depends on rsi_pkg.
module rsi_checker #(
    parameter int COORD_BITS = rsi_pkg::COORD_BITS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic                  o_hit,
    input logic [COORD_BITS-1:0] o_point_x,
    input logic [COORD_BITS-1:0] o_point_y
);

    // held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit)
            && $stable(o_point_x) && $stable(o_point_y))
        else $error("held result changed");

    // a miss carries a zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_point_x == '0 && o_point_y == '0)
        else $error("miss with nonzero point");

    // a held result backs up into the input
    a_backpress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input open while result held");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind ray_segment_intersect_unit rsi_checker #(
    .COORD_BITS (COORD_BITS)
) u_rsi_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_hit     (o_hit),
    .o_point_x (o_point_x),
    .o_point_y (o_point_y)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ray_segment_intersect_unit: directed and random transactions.
// Depends on rsi_pkg and the unit RTL; a scoreboard class predicts each crossing.
module testbench;

    localparam int CB = rsi_pkg::COORD_BITS;
    localparam int PIPE_DEPTH = CB + 7;  // stage count of the unit, per the RTL header
    localparam int N_RANDOM = 1230;

    typedef logic signed [CB-1:0] t_coord;

    typedef struct {
        logic   hit;
        t_coord px;
        t_coord py;
    } t_crossing;

    // Scoreboard: computes the expected crossing per accepted transaction, checks results.
    class crossing_scoreboard;
        t_crossing expected_q[$];
        int        n_mismatch;
        int        n_checked;
        int        n_hits;

        function t_crossing compute_crossing(t_coord c[rsi_pkg::N_COORDS]);
            longint x0, y0, x1, y1, u0, v0, u1, v1;
            longint a1, b1, c1, a2, b2, c2, det, nx, ny, px, py;
            t_crossing r;
            x0 = longint'(c[rsi_pkg::C_X0]); y0 = longint'(c[rsi_pkg::C_Y0]);
            x1 = longint'(c[rsi_pkg::C_X1]); y1 = longint'(c[rsi_pkg::C_Y1]);
            u0 = longint'(c[rsi_pkg::C_U0]); v0 = longint'(c[rsi_pkg::C_V0]);
            u1 = longint'(c[rsi_pkg::C_U1]); v1 = longint'(c[rsi_pkg::C_V1]);
            // line equations a*x + b*y + c = 0, everything exact in 64 bits
            a1 = y1 - y0; b1 = x0 - x1; c1 = y0 * x1 - x0 * y1;
            a2 = v1 - v0; b2 = u0 - u1; c2 = v0 * u1 - u0 * v1;
            det = a1 * b2 - a2 * b1;
            r.hit = 1'b0;
            r.px  = '0;
            r.py  = '0;
            if (det != 0) begin
                nx = b1 * c2 - b2 * c1;
                ny = a2 * c1 - a1 * c2;
                px = nx / det;  // truncates toward zero
                py = ny / det;
                // inclusive box on both axes, forward side of the ray per axis
                if (px >= ((u0 < u1) ? u0 : u1) && px <= ((u0 < u1) ? u1 : u0) &&
                    py >= ((v0 < v1) ? v0 : v1) && py <= ((v0 < v1) ? v1 : v0) &&
                    ((px > x0) == (x1 > x0)) && ((py > y0) == (y1 > y0))) begin
                    r.hit = 1'b1;
                    r.px  = t_coord'(px);
                    r.py  = t_coord'(py);
                end
            end
            return r;
        endfunction

        function void note_input(t_coord c[rsi_pkg::N_COORDS]);
            t_crossing r;
            r = compute_crossing(c);
            if (r.hit)
                n_hits++;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic hit, t_coord px, t_coord py);
            t_crossing e;
            n_checked++;
            if (expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: unexpected result hit=%0b x=%0d y=%0d", hit, px, py);
                return;
            end
            e = expected_q.pop_front();
            if (hit !== e.hit || px !== e.px || py !== e.py) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display({"ERROR: result %0d exp hit=%0b x=%0d y=%0d,",
                              " got hit=%0b x=%0d y=%0d"},
                             n_checked, e.hit, e.px, e.py, hit, px, py);
            end
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    t_coord i_ray_start_x, i_ray_start_y, i_ray_dir_x, i_ray_dir_y;
    t_coord i_seg_start_x, i_seg_start_y, i_seg_end_x, i_seg_end_y;
    logic   o_valid;
    logic   i_stall;
    logic   o_hit;
    t_coord o_point_x, o_point_y;

    crossing_scoreboard sb = new();

    ray_segment_intersect_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ray_start_x (i_ray_start_x),
        .i_ray_start_y (i_ray_start_y),
        .i_ray_dir_x   (i_ray_dir_x),
        .i_ray_dir_y   (i_ray_dir_y),
        .i_seg_start_x (i_seg_start_x),
        .i_seg_start_y (i_seg_start_y),
        .i_seg_end_x   (i_seg_end_x),
        .i_seg_end_y   (i_seg_end_y),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hit         (o_hit),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Gap length: mostly zero or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Input monitor: notes every accepted transaction at the rising edge.
    always @(posedge i_clk) begin
        t_coord c[rsi_pkg::N_COORDS];
        if (i_rst_n && i_valid && !o_stall) begin
            c[rsi_pkg::C_X0] = i_ray_start_x; c[rsi_pkg::C_Y0] = i_ray_start_y;
            c[rsi_pkg::C_X1] = i_ray_dir_x;   c[rsi_pkg::C_Y1] = i_ray_dir_y;
            c[rsi_pkg::C_U0] = i_seg_start_x; c[rsi_pkg::C_V0] = i_seg_start_y;
            c[rsi_pkg::C_U1] = i_seg_end_x;   c[rsi_pkg::C_V1] = i_seg_end_y;
            sb.note_input(c);
        end
    end

    // Output monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_hit, o_point_x, o_point_y);
    end

    // Result-side backpressure: stretches of free flow alternate with random stalls.
    initial begin
        int n;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = $urandom_range(5, 60);
            repeat (n) @(negedge i_clk) i_stall = 1'b0;
            n = $urandom_range(10, 80);
            repeat (n) begin
                @(negedge i_clk);
                i_stall = ($urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
                if ($urandom_range(0, 199) == 0) begin
                    i_stall = 1'b1;
                    repeat ($urandom_range(10, 40)) @(negedge i_clk);
                end
            end
        end
    end

    bit idle_free = 1'b0;

    // Drive one transaction from the falling edge and hold it until accepted.
    task automatic send_pair(t_coord x0, t_coord y0, t_coord x1, t_coord y1,
                             t_coord u0, t_coord v0, t_coord u1, t_coord v1);
        int gap;
        gap = idle_free ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_ray_start_x = x0; i_ray_start_y = y0;
        i_ray_dir_x   = x1; i_ray_dir_y   = y1;
        i_seg_start_x = u0; i_seg_start_y = v0;
        i_seg_end_x   = u1; i_seg_end_y   = v1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    function automatic t_coord rand_coord();
        // small coordinates most of the time, full range otherwise
        if ($urandom_range(0, 3) == 0)
            return t_coord'($urandom());
        return t_coord'($signed($urandom_range(0, 2047)) - 1024);
    endfunction

    function automatic t_coord clamp(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return t_coord'(v);
    endfunction

    // Aims the ray at a random point on a random wall, to produce many hits.
    task automatic send_aimed();
        t_coord u0, v0, u1, v1, x0, y0;
        longint tx, ty, k, lx0, ly0;
        longint f;
        u0 = rand_coord(); v0 = rand_coord();
        case ($urandom_range(0, 3))
            0: begin u1 = u0; v1 = rand_coord(); end        // vertical wall
            1: begin u1 = rand_coord(); v1 = v0; end        // horizontal wall
            default: begin u1 = rand_coord(); v1 = rand_coord(); end
        endcase
        f = longint'($urandom_range(0, 16));
        tx = longint'(u0) + ((longint'(u1) - longint'(u0)) * f) / 16;
        ty = longint'(v0) + ((longint'(v1) - longint'(v0)) * f) / 16;
        x0 = rand_coord(); y0 = rand_coord();
        lx0 = longint'(x0);
        ly0 = longint'(y0);
        k = longint'($urandom_range(0, 3));
        // second point past, at, or short of the target; sometimes behind the origin
        if ($urandom_range(0, 9) == 0)
            send_pair(x0, y0, clamp(2 * lx0 - tx), clamp(2 * ly0 - ty), u0, v0, u1, v1);
        else if (k == 0)
            send_pair(x0, y0, clamp(tx), clamp(ty), u0, v0, u1, v1);
        else
            send_pair(x0, y0, clamp(lx0 + (tx - lx0) * k / 2),
                      clamp(ly0 + (ty - ly0) * k / 2), u0, v0, u1, v1);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        {i_ray_start_x, i_ray_start_y, i_ray_dir_x, i_ray_dir_y} = '0;
        {i_seg_start_x, i_seg_start_y, i_seg_end_x, i_seg_end_y} = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, parallel/degenerate lines, axis-aligned walls,
        // box edges, backward rays, far-away crossings.
        send_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_pair(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                  16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_pair(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
                  16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_pair(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                  16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        // parallel
        send_pair(16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd16);
        // ray points coincide
        send_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32, -16'sd32, 16'sd32, 16'sd32);
        // zero-length wall
        send_pair(16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd32, 16'sd5, 16'sd32, 16'sd5);
        // vertical wall, hit
        send_pair(16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd32, -16'sd32, 16'sd32, 16'sd32);
        // horizontal wall, hit
        send_pair(16'sd0, 16'sd0, 16'sd0, 16'sd16, -16'sd32, 16'sd48, 16'sd32, 16'sd48);
        // wall behind the ray
        send_pair(16'sd0, 16'sd0, -16'sd16, 16'sd0, 16'sd32, -16'sd32, 16'sd32, 16'sd32);
        // hits wall endpoint
        send_pair(16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd32, 16'sd32, 16'sd64, 16'sd0);
        // hits wall endpoint at (33, 33)
        send_pair(16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd33, 16'sd33, 16'sd64, 16'sd0);
        // origin on the wall
        send_pair(16'sd32, 16'sd0, 16'sd32, 16'sd16, 16'sd32, 16'sd0, 16'sd64, 16'sd0);
        send_pair(16'sd0, 16'sd0, 16'sd16, 16'sd1,
                  16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send_pair(16'sd0, 16'sd0, 16'sd1, 16'sd16,
                  16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        // far crossing at wall endpoint
        send_pair(16'sd0, 16'sd0, 16'sd1, 16'sd1,
                  16'sd32000, 16'sd32000, 16'sd32001, 16'sd32002);
        send_pair(-16'sd100, 16'sd7, 16'sd300, 16'sd9,
                  16'sd50, -16'sd400, 16'sd51, 16'sd400);
        send_pair(16'sd5, 16'sd5, -16'sd3, -16'sd11,
                  -16'sd400, -16'sd50, 16'sd400, -16'sd49);
        send_pair(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555,
                  16'sh5555, 16'sh5555, 16'shAAAA, 16'shAAAA);

        // Random: mostly aimed rays, some pure noise, in stretches with and without gaps.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0)
                idle_free = ($urandom_range(0, 2) == 0);
            if (n == N_RANDOM / 2) begin
                // drain the pipeline completely once before carrying on
                i_valid = 1'b0;
                while (sb.expected_q.size() != 0) @(negedge i_clk);
            end
            if ($urandom_range(0, 3) == 0)
                send_pair(t_coord'($urandom()), t_coord'($urandom()), t_coord'($urandom()),
                          t_coord'($urandom()), t_coord'($urandom()), t_coord'($urandom()),
                          t_coord'($urandom()), t_coord'($urandom()));
            else
                send_aimed();
        end
        i_valid = 1'b0;

        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 10) @(negedge i_clk);

        $display("Checked %0d crossings (%0d predicted hits), incl. extremes, parallel,",
                 sb.n_checked, sb.n_hits);
        $display("degenerate and axis-aligned cases under random gaps and backpressure.");
        if (sb.n_mismatch == 0 && sb.expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("Mismatches: %0d, results missing: %0d",
                     sb.n_mismatch, sb.expected_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding", sb.expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
